/* src/enms_pkg.sv */
`default_nettype none

package enms_pkg;

  localparam int unsigned MaxWidthDefault    = 2048;
  localparam int unsigned MagFracBitsDefault = 4;

  localparam int unsigned MagW     = 12;
  localparam int unsigned DirW     = 9;
  localparam int unsigned RowW     = 16;
  localparam int unsigned OutColW  = 11;
  localparam int unsigned ValW     = 8;
  localparam int unsigned ImgWidthW  = 12;
  localparam int unsigned ImgHeightW = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIndexW  = 2;

  localparam logic [ImgWidthW-1:0]  ImageWidthReset    = 12'd640;
  localparam logic [ImgHeightW-1:0] ImageHeightReset   = 16'd480;
  localparam logic [ValW-1:0]       LowThresholdReset  = 8'd50;
  localparam logic [ValW-1:0]       HighThresholdReset = 8'd100;

  localparam logic [ValW-1:0] ValMax = 8'd255;

  // Direction bin limits in half-degree units: 22.5, 67.5, 112.5, 157.5 and 180 degrees.
  localparam logic [DirW-1:0] DirLim22  = 9'd45;
  localparam logic [DirW-1:0] DirLim67  = 9'd135;
  localparam logic [DirW-1:0] DirLim112 = 9'd225;
  localparam logic [DirW-1:0] DirLim157 = 9'd315;
  localparam logic [DirW-1:0] DirFull   = 9'd360;

  typedef enum logic [CfgIndexW-1:0] {
    CfgImageWidth    = 2'd0,
    CfgImageHeight   = 2'd1,
    CfgLowThreshold  = 2'd2,
    CfgHighThreshold = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    EdgeNone   = 2'd0,
    EdgeWeak   = 2'd1,
    EdgeStrong = 2'd2
  } edge_class_e;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic [DirW-1:0] direction;
    logic            frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [ValW-1:0]    kept_value;
    edge_class_e        edge_class;
    logic [RowW-1:0]    out_row;
    logic [OutColW-1:0] out_col;
  } pixel_out_t;

  typedef struct packed {
    logic [MagW-1:0] mag_centre;
    logic [MagW-1:0] mag_above;
    logic [DirW-1:0] dir_centre;
  } line_word_t;

endpackage

`default_nettype wire

/* src/edge_nms_double_threshold.sv */
`default_nettype none

// Canny non-maximum suppression with double-threshold classing for a raster pixel
// stream: one pixel is taken every clock unless a stalled output holds it back, and
// each result describes the pixel one line and one column behind the one just
// accepted, so the last line and column of a frame give no result. A pixel first
// passes the line buffer read, then the 3x3 window, the suppression and the class,
// after which the result sits in the output register; the rate is set by the single
// line buffer memory of MAX_WIDTH words, which takes one read and one write every
// clock. The line buffer needs no clearing after reset: a kept value only uses
// entries written by the two lines before it, as long as the image width does not
// grow inside a frame. The user must write image size and thresholds through the
// configuration port only while no pixel is in flight; the block does not check it.
module edge_nms_double_threshold #(
  parameter int unsigned MAX_WIDTH     = enms_pkg::MaxWidthDefault,
  parameter int unsigned MAG_FRAC_BITS = enms_pkg::MagFracBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire enms_pkg::pixel_in_t                in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output enms_pkg::pixel_out_t                    out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [enms_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  wire logic [enms_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  logic [enms_pkg::ImgWidthW-1:0]  width_q;
  logic [enms_pkg::ImgHeightW-1:0] height_q;
  logic [enms_pkg::ValW-1:0]       low_q, high_q;

  logic                      in_acc;
  logic [enms_pkg::RowW-1:0] pos_row;
  logic [ColW-1:0]           pos_col;

  logic                      s1_valid_q;
  logic [enms_pkg::MagW-1:0] s1_mag_q;
  logic [enms_pkg::DirW-1:0] s1_dir_q;
  logic [enms_pkg::RowW-1:0] s1_row_q;
  logic [ColW-1:0]           s1_col_q;
  logic                      s1_emit, s1_interior, s1_adv;
  logic [ColW-1:0]           s1_col_m1;

  logic                 byp_q;
  enms_pkg::line_word_t byp_word_q;
  enms_pkg::line_word_t rd_word, word, wr_word;

  logic [enms_pkg::ValW-1:0] kept;
  enms_pkg::edge_class_e     cls;

  logic                 out_valid_q;
  enms_pkg::pixel_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= enms_pkg::ImageWidthReset;
      height_q <= enms_pkg::ImageHeightReset;
      low_q    <= enms_pkg::LowThresholdReset;
      high_q   <= enms_pkg::HighThresholdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        enms_pkg::CfgImageWidth:    width_q  <= cfg_wdata_i[enms_pkg::ImgWidthW-1:0];
        enms_pkg::CfgImageHeight:   height_q <= cfg_wdata_i[enms_pkg::ImgHeightW-1:0];
        enms_pkg::CfgLowThreshold:  low_q    <= cfg_wdata_i[enms_pkg::ValW-1:0];
        enms_pkg::CfgHighThreshold: high_q   <= cfg_wdata_i[enms_pkg::ValW-1:0];
      endcase
    end
  end

  assign s1_emit     = (s1_row_q != '0) && (s1_col_q != '0);
  assign s1_interior = (s1_row_q > 16'd1) && (s1_col_q > ColW'(1));
  assign s1_adv      = s1_valid_q && (!s1_emit || !out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;

  enms_pos #(
    .MaxWidth(MAX_WIDTH)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .frame_start_i (in_data_i.frame_start),
    .img_width_i   (width_q),
    .img_height_i  (height_q),
    .row_o         (pos_row),
    .col_o         (pos_col)
  );

  enms_linebuf #(
    .Depth(MAX_WIDTH),
    .Width($bits(enms_pkg::line_word_t))
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (pos_col),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_word)
  );

  // A pixel read from the column being written in the same clock takes the new word.
  assign word    = byp_q ? byp_word_q : rd_word;
  assign wr_word = '{mag_centre: s1_mag_q, mag_above: word.mag_centre, dir_centre: s1_dir_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        byp_q      <= s1_adv && (s1_col_q == pos_col);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mag_q   <= in_data_i.magnitude;
      s1_dir_q   <= in_data_i.direction;
      s1_row_q   <= pos_row;
      s1_col_q   <= pos_col;
      byp_word_q <= wr_word;
    end
  end

  enms_nms #(
    .MagFracBits(MAG_FRAC_BITS)
  ) u_nms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (s1_adv),
    .col_top_i  (word.mag_above),
    .col_mid_i  (word.mag_centre),
    .col_bot_i  (s1_mag_q),
    .dir_next_i (word.dir_centre),
    .interior_i (s1_interior),
    .low_thr_i  (low_q),
    .high_thr_i (high_q),
    .kept_o     (kept),
    .class_o    (cls)
  );

  assign s1_col_m1 = s1_col_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_data_q <= '{kept_value: kept,
                      edge_class: cls,
                      out_row:    s1_row_q - 1'b1,
                      out_col:    enms_pkg::OutColW'(s1_col_m1)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* src/enms_pos.sv */
`default_nettype none

module enms_pos #(
  parameter int unsigned MaxWidth = enms_pkg::MaxWidthDefault,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned WidW = $clog2(MaxWidth + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic                             frame_start_i,
  input  wire logic [enms_pkg::ImgWidthW-1:0]   img_width_i,
  input  wire logic [enms_pkg::ImgHeightW-1:0]  img_height_i,
  output logic      [enms_pkg::RowW-1:0]        row_o,
  output logic      [ColW-1:0]                  col_o
);

  logic [ColW-1:0]                 col_q, col_d;
  logic [enms_pkg::RowW-1:0]       row_q, row_d;
  logic [WidW-1:0]                 wid;
  logic [enms_pkg::ImgHeightW-1:0] hei;
  logic [ColW-1:0]                 col_s;
  logic [enms_pkg::RowW:0]         row_s;
  logic [WidW-1:0]                 col_nx;
  logic [enms_pkg::RowW:0]         row_nx;

  always_comb begin
    if (img_width_i < 12'd3) begin
      wid = WidW'(3);
    end else if (32'(img_width_i) > MaxWidth) begin
      wid = WidW'(MaxWidth);
    end else begin
      wid = WidW'(img_width_i);
    end
    hei = (img_height_i < 16'd3) ? 16'd3 : img_height_i;
  end

  // Position of the incoming pixel, with wrap for counters left beyond the frame size.
  always_comb begin
    col_s = frame_start_i ? '0 : col_q;
    row_s = frame_start_i ? '0 : {1'b0, row_q};
    if (WidW'(col_s) >= wid) begin
      col_s = '0;
      row_s = row_s + 1'b1;
    end
    if (row_s >= {1'b0, hei}) begin
      row_s = '0;
    end
    row_o = row_s[enms_pkg::RowW-1:0];
    col_o = col_s;
  end

  always_comb begin
    col_nx = WidW'(col_o) + 1'b1;
    row_nx = {1'b0, row_o} + 1'b1;
    if (col_nx >= wid) begin
      col_d = '0;
      row_d = (row_nx >= {1'b0, hei}) ? '0 : row_nx[enms_pkg::RowW-1:0];
    end else begin
      col_d = col_nx[ColW-1:0];
      row_d = row_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

/* src/enms_linebuf.sv */
`default_nettype none

module enms_linebuf #(
  parameter int unsigned Depth = enms_pkg::MaxWidthDefault,
  parameter int unsigned Width = $bits(enms_pkg::line_word_t),
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* src/enms_nms.sv */
`default_nettype none

module enms_nms #(
  parameter int unsigned MagFracBits = enms_pkg::MagFracBitsDefault,
  localparam int unsigned IntW = enms_pkg::MagW - MagFracBits,
  localparam int unsigned ExtW = (IntW > enms_pkg::ValW) ? IntW : enms_pkg::ValW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          advance_i,
  input  wire logic [enms_pkg::MagW-1:0]     col_top_i,
  input  wire logic [enms_pkg::MagW-1:0]     col_mid_i,
  input  wire logic [enms_pkg::MagW-1:0]     col_bot_i,
  input  wire logic [enms_pkg::DirW-1:0]     dir_next_i,
  input  wire logic                          interior_i,
  input  wire logic [enms_pkg::ValW-1:0]     low_thr_i,
  input  wire logic [enms_pkg::ValW-1:0]     high_thr_i,
  output logic      [enms_pkg::ValW-1:0]     kept_o,
  output enms_pkg::edge_class_e              class_o
);

  logic [enms_pkg::MagW-1:0] top0_q, top1_q, mid0_q, mid1_q, bot0_q, bot1_q;
  logic [enms_pkg::DirW-1:0] dir_q;
  logic [ExtW-1:0]           centre, qa, qb;

  function automatic logic [ExtW-1:0] int_part(input logic [enms_pkg::MagW-1:0] m);
    return ExtW'(m[enms_pkg::MagW-1:MagFracBits]);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top0_q <= '0;
      top1_q <= '0;
      mid0_q <= '0;
      mid1_q <= '0;
      bot0_q <= '0;
      bot1_q <= '0;
      dir_q  <= '0;
    end else if (advance_i) begin
      top0_q <= top1_q;
      top1_q <= col_top_i;
      mid0_q <= mid1_q;
      mid1_q <= col_mid_i;
      bot0_q <= bot1_q;
      bot1_q <= col_bot_i;
      dir_q  <= dir_next_i;
    end
  end

  // The window after this pixel's shift has the new column on the right.
  always_comb begin
    centre = int_part(mid1_q);
    priority if (dir_q < enms_pkg::DirLim22 ||
                 (dir_q >= enms_pkg::DirLim157 && dir_q <= enms_pkg::DirFull)) begin
      qa = int_part(col_mid_i);
      qb = int_part(mid0_q);
    end else if (dir_q < enms_pkg::DirLim67) begin
      qa = int_part(bot0_q);
      qb = int_part(col_top_i);
    end else if (dir_q < enms_pkg::DirLim112) begin
      qa = int_part(bot1_q);
      qb = int_part(top1_q);
    end else if (dir_q < enms_pkg::DirLim157) begin
      qa = int_part(top0_q);
      qb = int_part(col_bot_i);
    end else begin
      qa = ExtW'(enms_pkg::ValMax);
      qb = ExtW'(enms_pkg::ValMax);
    end

    if (interior_i && centre >= qa && centre >= qb) begin
      kept_o = (centre > ExtW'(enms_pkg::ValMax)) ? enms_pkg::ValMax
                                                   : centre[enms_pkg::ValW-1:0];
    end else begin
      kept_o = '0;
    end

    priority if (kept_o < low_thr_i) begin
      class_o = enms_pkg::EdgeNone;
    end else if (kept_o > high_thr_i) begin
      class_o = enms_pkg::EdgeStrong;
    end else begin
      class_o = enms_pkg::EdgeWeak;
    end
  end

endmodule

`default_nettype wire

/* src/enms_checker.sv */
`default_nettype none

module enms_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire enms_pkg::pixel_out_t           out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Pixels on the first row or column of a frame are never kept.
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_row == '0 || out_data_o.out_col == '0)
      |-> out_data_o.kept_value == '0)
    else $error("border pixel kept");

  // A result that appears on an empty output comes from a request taken before it, held in the input stage.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

endmodule

bind edge_nms_double_threshold enms_checker u_enms_checker (.*);

`default_nettype wire

/* tb/edge_nms_double_threshold_tb.sv */
`default_nettype none

module edge_nms_double_threshold_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseItems = 130;

  // Direction values on both sides of every bin limit, plus the first value past 180 degrees.
  localparam logic [enms_pkg::DirW-1:0] DirEdges [10] = '{
    enms_pkg::DirLim22 - 9'd1, enms_pkg::DirLim22,
    enms_pkg::DirLim67 - 9'd1, enms_pkg::DirLim67,
    enms_pkg::DirLim112 - 9'd1, enms_pkg::DirLim112,
    enms_pkg::DirLim157 - 9'd1, enms_pkg::DirLim157,
    enms_pkg::DirFull, enms_pkg::DirFull + 9'd1
  };

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  enms_pkg::pixel_in_t            in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  enms_pkg::pixel_out_t           out_data_o;
  logic                           cfg_we_i = 1'b0;
  logic [enms_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [enms_pkg::CfgDataW-1:0]  cfg_wdata_i = '0;

  edge_nms_double_threshold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [enms_pkg::ImgWidthW-1:0]  cfg_width  = enms_pkg::ImageWidthReset;
  logic [enms_pkg::ImgHeightW-1:0] cfg_height = enms_pkg::ImageHeightReset;
  logic [enms_pkg::ValW-1:0]       cfg_low    = enms_pkg::LowThresholdReset;
  logic [enms_pkg::ValW-1:0]       cfg_high   = enms_pkg::HighThresholdReset;

  logic [enms_pkg::MagW-1:0] older_line_mag [enms_pkg::MaxWidthDefault] = '{default: '0};
  logic [enms_pkg::MagW-1:0] newer_line_mag [enms_pkg::MaxWidthDefault] = '{default: '0};
  logic [enms_pkg::DirW-1:0] newer_line_dir [enms_pkg::MaxWidthDefault] = '{default: '0};
  logic [enms_pkg::MagW-1:0] mag_win [9] = '{default: '0};
  logic [enms_pkg::DirW-1:0] dir_lag = '0;
  int unsigned               pred_row = 0;
  int unsigned               pred_col = 0;

  enms_pkg::pixel_out_t pending_edges [$];
  int unsigned          pixels_sent = 0;
  int unsigned          edges_checked = 0;
  int unsigned          err_count = 0;
  int unsigned          config_count = 0;
  int unsigned          cycles = 0;
  bit                   sender_idles = 1'b1;
  bit                   sink_stalls = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > enms_pkg::MaxWidthDefault) w = enms_pkg::MaxWidthDefault;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height < 3) ? 3 : cfg_height;
  endfunction

  function automatic int unsigned int_mag(int unsigned idx);
    return mag_win[idx] >> enms_pkg::MagFracBitsDefault;
  endfunction

  function automatic int unsigned suppressed_mag(logic [enms_pkg::DirW-1:0] dir);
    int unsigned centre, qa, qb;
    centre = int_mag(4);
    qa = 255;
    qb = 255;
    if (dir < enms_pkg::DirLim22 ||
        (dir >= enms_pkg::DirLim157 && dir <= enms_pkg::DirFull)) begin
      qa = int_mag(5);
      qb = int_mag(3);
    end else if (dir >= enms_pkg::DirLim22 && dir < enms_pkg::DirLim67) begin
      qa = int_mag(6);
      qb = int_mag(2);
    end else if (dir >= enms_pkg::DirLim67 && dir < enms_pkg::DirLim112) begin
      qa = int_mag(7);
      qb = int_mag(1);
    end else if (dir >= enms_pkg::DirLim112 && dir < enms_pkg::DirLim157) begin
      qa = int_mag(0);
      qb = int_mag(8);
    end
    if (centre >= qa && centre >= qb) return (centre > 255) ? 255 : centre;
    return 0;
  endfunction

  function automatic void predict_nms(enms_pkg::pixel_in_t px);
    int unsigned wid, hei, r, c, kept;
    logic [enms_pkg::MagW-1:0] top, mid;
    logic [enms_pkg::DirW-1:0] cdir;
    enms_pkg::pixel_out_t res;
    wid = eff_width();
    hei = eff_height();
    if (px.frame_start) begin
      pred_row = 0;
      pred_col = 0;
    end
    if (pred_col >= wid) begin
      pred_col = 0;
      pred_row++;
    end
    if (pred_row >= hei) pred_row = 0;
    r = pred_row;
    c = pred_col;
    top = older_line_mag[c];
    mid = newer_line_mag[c];
    for (int k = 0; k < 3; k++) begin
      mag_win[k * 3] = mag_win[k * 3 + 1];
      mag_win[k * 3 + 1] = mag_win[k * 3 + 2];
    end
    mag_win[2] = top;
    mag_win[5] = mid;
    mag_win[8] = px.magnitude;
    cdir = dir_lag;
    dir_lag = newer_line_dir[c];
    older_line_mag[c] = mid;
    newer_line_mag[c] = px.magnitude;
    newer_line_dir[c] = px.direction;
    if (r >= 1 && c >= 1) begin
      kept = (r >= 2 && c >= 2) ? suppressed_mag(cdir) : 0;
      res.kept_value = enms_pkg::ValW'(kept);
      if (kept < cfg_low) res.edge_class = enms_pkg::EdgeNone;
      else if (kept > cfg_high) res.edge_class = enms_pkg::EdgeStrong;
      else res.edge_class = enms_pkg::EdgeWeak;
      res.out_row = enms_pkg::RowW'(r - 1);
      res.out_col = enms_pkg::OutColW'(c - 1);
      pending_edges.insert(pending_edges.size(), res);
    end
    if (c + 1 >= wid) begin
      pred_col = 0;
      pred_row = (r + 1 >= hei) ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
    end
  endfunction

  function automatic void compare_edge(enms_pkg::pixel_out_t got);
    enms_pkg::pixel_out_t want;
    if (pending_edges.size() == 0) begin
      $error("unexpected result: row %0d col %0d", got.out_row, got.out_col);
      err_count++;
      return;
    end
    want = pending_edges.pop_front();
    edges_checked++;
    if (got.kept_value !== want.kept_value) begin
      $error("kept_value: expected %0d, got %0d", want.kept_value, got.kept_value);
      err_count++;
    end
    if (got.edge_class !== want.edge_class) begin
      $error("edge_class: expected %0d, got %0d", want.edge_class, got.edge_class);
      err_count++;
    end
    if (got.out_row !== want.out_row) begin
      $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
      err_count++;
    end
    if (got.out_col !== want.out_col) begin
      $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_nms(in_data_i);
      if (out_valid_o && !out_stall_i) compare_edge(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_edges.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i && sink_stalls) begin
        hold = $urandom_range(0, 3);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_pixel(input enms_pkg::pixel_in_t px);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [enms_pkg::ImgWidthW-1:0] w,
                            input logic [enms_pkg::ImgHeightW-1:0] h,
                            input logic [enms_pkg::ValW-1:0] lo,
                            input logic [enms_pkg::ValW-1:0] hi);
    cfg_we_i <= 1'b1;
    cfg_index_i <= enms_pkg::CfgImageWidth;
    cfg_wdata_i <= enms_pkg::CfgDataW'(w);
    @(posedge clk_i);
    cfg_index_i <= enms_pkg::CfgImageHeight;
    cfg_wdata_i <= enms_pkg::CfgDataW'(h);
    @(posedge clk_i);
    cfg_index_i <= enms_pkg::CfgLowThreshold;
    cfg_wdata_i <= enms_pkg::CfgDataW'(lo);
    @(posedge clk_i);
    cfg_index_i <= enms_pkg::CfgHighThreshold;
    cfg_wdata_i <= enms_pkg::CfgDataW'(hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_width = w;
    cfg_height = h;
    cfg_low = lo;
    cfg_high = hi;
    config_count++;
  endtask

  function automatic enms_pkg::pixel_in_t rand_pixel(bit fs);
    enms_pkg::pixel_in_t px;
    case ($urandom_range(0, 9))
      0: px.magnitude = '0;
      1: px.magnitude = '1;
      default: px.magnitude = enms_pkg::MagW'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0: px.direction = enms_pkg::DirW'($urandom_range(361, 511));
      1: px.direction = DirEdges[$urandom_range(0, 9)];
      default: px.direction = enms_pkg::DirW'($urandom_range(0, 360));
    endcase
    px.frame_start = fs;
    return px;
  endfunction

  function automatic logic [enms_pkg::ValW-1:0] rand_threshold();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return enms_pkg::ValW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_run(input int unsigned n, input bit with_start);
    for (int unsigned i = 0; i < n; i++) send_pixel(rand_pixel(with_start && i == 0));
  endtask

  // Sends one frame at the current size, now and then cut short or restarted midway.
  task automatic send_frame(input bit with_start, input int unsigned cap);
    int unsigned total;
    total = eff_width() * eff_height();
    if (total > cap) total = cap;
    for (int unsigned n = 0; n < total; n++) begin
      if (n != 0 && $urandom_range(0, 199) == 0) break;
      send_pixel(rand_pixel((with_start && n == 0) || $urandom_range(0, 149) == 0));
    end
  endtask

  task automatic test_direction_bins();
    enms_pkg::pixel_in_t px;
    sender_idles = 1'b1;
    sink_stalls = 1'b1;
    set_config(12'd7, 16'd4, 8'd60, 8'd180);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 7; c++) begin
        px = rand_pixel(r == 0 && c == 0);
        if ((r + c) % 3 == 0) px.magnitude = '1;
        else if ((r * 7 + c) % 4 == 0) px.magnitude = '0;
        if (r >= 1 && r <= 2 && c >= 1 && c <= 5) px.direction = DirEdges[(r - 1) * 5 + c - 1];
        send_pixel(px);
      end
    end
    wait_idle();
  endtask

  task automatic test_thresholds();
    logic [enms_pkg::ValW-1:0] lows [6] = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd1};
    logic [enms_pkg::ValW-1:0] highs [6] = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd254};
    for (int i = 0; i < 6; i++) begin
      set_config(12'd6, 16'd5, lows[i], highs[i]);
      send_frame(1'b1, 1000);
      wait_idle();
    end
  endtask

  task automatic test_size_clamp();
    set_config(12'd0, 16'd0, 8'd30, 8'd90);
    send_frame(1'b1, 1000);
    send_frame(1'b0, 1000);
    wait_idle();
    set_config(12'd2, 16'd1, 8'd20, 8'd200);
    send_frame(1'b1, 1000);
    wait_idle();
    set_config(12'd4, 16'hFFFF, 8'd50, 8'd100);
    send_frame(1'b1, 48);
    wait_idle();
  endtask

  task automatic test_size_change_midframe();
    set_config(12'd10, 16'd8, 8'd40, 8'd120);
    send_run(35, 1'b1);
    wait_idle();
    set_config(12'd4, 16'd8, 8'd40, 8'd120);
    send_run(10, 1'b0);
    wait_idle();
    set_config(12'd4, 16'd3, 8'd40, 8'd120);
    send_run(20, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    logic [enms_pkg::ImgWidthW-1:0] w;
    logic [enms_pkg::ImgHeightW-1:0] h;
    for (int phase = 0; phase < 12; phase++) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: w = enms_pkg::ImgWidthW'($urandom_range(0, 2));
        1: w = enms_pkg::ImgWidthW'($urandom_range(11, 40));
        default: w = enms_pkg::ImgWidthW'($urandom_range(3, 10));
      endcase
      h = ($urandom_range(0, 9) == 0) ? enms_pkg::ImgHeightW'($urandom_range(0, 2))
                                      : enms_pkg::ImgHeightW'($urandom_range(3, 7));
      set_config(w, h, rand_threshold(), rand_threshold());
      start = pixels_sent;
      send_frame(1'b1, PhaseItems);
      while (pixels_sent - start < PhaseItems)
        send_frame($urandom_range(0, 3) != 0, PhaseItems - (pixels_sent - start));
      wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_direction_bins();
    test_thresholds();
    test_size_clamp();
    test_size_change_midframe();
    test_random_frames();
    wait_idle();
    $display("Sent %0d pixels and checked %0d results over %0d size and threshold settings,",
             pixels_sent, edges_checked, config_count);
    $display("including every direction bin limit, clamped sizes and mid-frame size changes.");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
